// ===== hdl/dqip_pkg.sv =====
// Package: shared types and constants for the dotted-quad IPv4 text checker.
`default_nettype none

package dqip_pkg;

   localparam int unsigned CharWidth   = 8;
   localparam int unsigned AddrWidth   = 32;
   localparam int unsigned OctetWidth  = 10;
   localparam int unsigned CountWidth  = 2;

   localparam logic [OctetWidth-1:0] OctetMax  = 10'd255;
   localparam logic [CountWidth-1:0] DigitsMax = 2'd3;
   localparam logic [CountWidth-1:0] DotsMax   = 2'd3;
   localparam logic [CharWidth-1:0]  DotChar   = 8'h2E;
   localparam logic [CharWidth-1:0]  ZeroChar  = 8'h30;
   localparam logic [CharWidth-1:0]  NineChar  = 8'h39;

   typedef enum logic [1:0] {
      ST_PARSING = 2'd0,
      ST_DONE    = 2'd1,
      ST_BAD     = 2'd2
   } parse_status_type;

   typedef struct packed {
      logic [CharWidth-1:0] char_code;
      logic                 line_end;
   } req_data_type;

   typedef struct packed {
      logic                 addr_valid;
      logic [AddrWidth-1:0] address;
   } rsp_data_type;

endpackage

`default_nettype wire

// ===== hdl/dotted_quad_ipv4_text_check_core.sv =====
// Dotted-quad IPv4 text checker: request register, parser and response register.
//
// Usage: feed a text line one character per request on req_data.char_code,
// with req_data.line_end set on the last character. Each line yields exactly
// one response on its last character: rsp_data.addr_valid is 1 when the line
// starts with a valid dotted-quad address (octets of one to three digits,
// each at most 255), and rsp_data.address holds the four octets, first octet
// in bits 31..24, or zero when the line is invalid.
// Path: a line's last character is held in the request register, and its
// result is registered in the response register that drives rsp_valid.
// Throughput: one character per cycle unless a line end waits on a full
// response register; the parser updates its counters once per character.
// Reset: synchronous and active high; clears the parser to the start of a
// line and drops any held request or response.
// Stall: the response register holds its result until rsp_ready; while it is
// full, characters that end no line keep flowing, and a line-end character
// waits in the request register until the response slot frees.
`default_nettype none

module dotted_quad_ipv4_text_check_core (
   input  wire                          clock,
   input  wire                          reset,
   input  wire                          req_valid,
   output logic                         req_ready,
   input  wire dqip_pkg::req_data_type  req_data,
   output logic                         rsp_valid,
   input  wire                          rsp_ready,
   output dqip_pkg::rsp_data_type       rsp_data
);

   logic                     in_valid_ff, in_valid_in;
   dqip_pkg::req_data_type   in_data_ff, in_data_in;
   logic                     out_valid_ff, out_valid_in;
   dqip_pkg::rsp_data_type   out_data_ff, out_data_in;

   logic                     out_free;
   logic                     advance;
   logic                     emit;
   dqip_pkg::rsp_data_type   line_result;

   assign out_free  = !out_valid_ff || rsp_ready;
   assign advance   = in_valid_ff && (!in_data_ff.line_end || out_free);
   assign emit      = advance && in_data_ff.line_end;
   assign req_ready = !in_valid_ff || advance;

   dqip_parser u_parser (
      .clock     (clock),
      .reset     (reset),
      .step_en   (advance),
      .step_data (in_data_ff),
      .result    (line_result)
   );

   always_comb begin
      in_valid_in = in_valid_ff;
      in_data_in  = in_data_ff;
      if (req_ready) begin
         in_valid_in = req_valid;
         in_data_in  = req_data;
      end
   end

   always_comb begin
      out_valid_in = out_valid_ff;
      out_data_in  = out_data_ff;
      if (emit) begin
         out_valid_in = 1'b1;
         out_data_in  = line_result;
      end else if (rsp_ready) begin
         out_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
      end
      in_data_ff  <= in_data_in;
      out_data_ff <= out_data_in;
   end

   assign rsp_valid = out_valid_ff;
   assign rsp_data  = out_data_ff;

   a_invalid_zero: assert property (@(posedge clock) disable iff (reset)
      out_valid_ff && !out_data_ff.addr_valid |-> out_data_ff.address == '0)
      else $error("invalid response carries an address");

   a_emit_fills: assert property (@(posedge clock) disable iff (reset)
      emit |=> out_valid_ff)
      else $error("line end did not produce a response");

   a_request_hold: assert property (@(posedge clock) disable iff (reset)
      in_valid_ff && !advance |=> in_valid_ff && $stable(in_data_ff))
      else $error("blocked request was lost");

endmodule

`default_nettype wire

// ===== hdl/dqip_parser.sv =====
// Parser: per-character octet, digit and dot tracking with the line result.
`default_nettype none

module dqip_parser (
   input  wire                          clock,
   input  wire                          reset,
   input  wire                          step_en,
   input  wire dqip_pkg::req_data_type  step_data,
   output dqip_pkg::rsp_data_type       result
);

   dqip_pkg::parse_status_type              status_ff, status_in, status_mid;
   logic [dqip_pkg::OctetWidth-1:0]         octet_ff, octet_in, octet_mid;
   logic [dqip_pkg::CountWidth-1:0]         digits_ff, digits_in, digits_mid;
   logic [dqip_pkg::CountWidth-1:0]         dots_ff, dots_in, dots_mid;
   logic [dqip_pkg::AddrWidth-1:0]          acc_ff, acc_in, acc_mid;

   logic                                    is_digit;
   logic                                    is_dot;
   logic [3:0]                              digit_val;
   logic [11:0]                             octet_mul;
   logic [dqip_pkg::AddrWidth-1:0]          acc_push;
   logic                                    fin_push;
   logic                                    line_ok;

   assign is_digit  = (step_data.char_code >= dqip_pkg::ZeroChar) &&
                      (step_data.char_code <= dqip_pkg::NineChar);
   assign is_dot    = (step_data.char_code == dqip_pkg::DotChar);
   assign digit_val = 4'(step_data.char_code - dqip_pkg::ZeroChar);
   assign octet_mul = ({2'b00, octet_ff} << 3) + ({2'b00, octet_ff} << 1) +
                      {8'd0, digit_val};
   assign acc_push  = {acc_ff[dqip_pkg::AddrWidth-9:0], octet_ff[7:0]};

   // Character step: update the running octet, counters and status.
   always_comb begin
      status_mid = status_ff;
      octet_mid  = octet_ff;
      digits_mid = digits_ff;
      dots_mid   = dots_ff;
      acc_mid    = acc_ff;
      if (status_ff == dqip_pkg::ST_PARSING) begin
         priority if (is_digit) begin
            if (digits_ff == dqip_pkg::DigitsMax) begin
               status_mid = dqip_pkg::ST_BAD;
            end else begin
               octet_mid  = octet_mul[dqip_pkg::OctetWidth-1:0];
               digits_mid = digits_ff + 2'd1;
               if (octet_mul > {2'b00, dqip_pkg::OctetMax}) begin
                  status_mid = dqip_pkg::ST_BAD;
               end
            end
         end else if (is_dot) begin
            if (dots_ff != dqip_pkg::DotsMax && digits_ff != '0) begin
               acc_mid    = acc_push;
               octet_mid  = '0;
               digits_mid = '0;
               dots_mid   = dots_ff + 2'd1;
            end else begin
               status_mid = dqip_pkg::ST_BAD;
            end
         end else begin
            if (dots_ff == dqip_pkg::DotsMax && digits_ff != '0) begin
               acc_mid    = acc_push;
               octet_mid  = '0;
               digits_mid = '0;
               status_mid = dqip_pkg::ST_DONE;
            end else begin
               status_mid = dqip_pkg::ST_BAD;
            end
         end
      end
   end

   // Line end closes a fourth octet still open.
   assign fin_push = step_data.line_end && (status_mid == dqip_pkg::ST_PARSING) &&
                     (dots_mid == dqip_pkg::DotsMax) && (digits_mid != '0);
   assign line_ok  = (status_mid == dqip_pkg::ST_DONE) || fin_push;

   // Next state: on an accepted character, restart at line end, else take the step.
   always_comb begin
      status_in = status_ff;
      octet_in  = octet_ff;
      digits_in = digits_ff;
      dots_in   = dots_ff;
      acc_in    = acc_ff;
      if (step_en) begin
         if (step_data.line_end) begin
            status_in = dqip_pkg::ST_PARSING;
            octet_in  = '0;
            digits_in = '0;
            dots_in   = '0;
            acc_in    = '0;
         end else begin
            status_in = status_mid;
            octet_in  = octet_mid;
            digits_in = digits_mid;
            dots_in   = dots_mid;
            acc_in    = acc_mid;
         end
      end
   end

   // Output: result of the line ending on this character.
   always_comb begin
      result.addr_valid = line_ok;
      if (!line_ok) begin
         result.address = '0;
      end else if (fin_push) begin
         result.address = {acc_mid[dqip_pkg::AddrWidth-9:0], octet_mid[7:0]};
      end else begin
         result.address = acc_mid;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         status_ff <= dqip_pkg::ST_PARSING;
         octet_ff  <= '0;
         digits_ff <= '0;
         dots_ff   <= '0;
         acc_ff    <= '0;
      end else begin
         status_ff <= status_in;
         octet_ff  <= octet_in;
         digits_ff <= digits_in;
         dots_ff   <= dots_in;
         acc_ff    <= acc_in;
      end
   end

   a_line_restart: assert property (@(posedge clock) disable iff (reset)
      step_en && step_data.line_end |=>
         status_ff == dqip_pkg::ST_PARSING && dots_ff == '0 && digits_ff == '0)
      else $error("parser did not restart after line end");

   a_octet_range: assert property (@(posedge clock) disable iff (reset)
      status_ff == dqip_pkg::ST_PARSING |-> octet_ff <= dqip_pkg::OctetMax)
      else $error("octet above limit while parsing");

   a_done_closed: assert property (@(posedge clock) disable iff (reset)
      status_ff == dqip_pkg::ST_DONE |-> digits_ff == '0 && dots_ff == dqip_pkg::DotsMax)
      else $error("completed address with open octet");

endmodule

`default_nettype wire
